// ===== rtl/itp_pkg.sv =====
// Shared types, operator codes and character tables for the infix-to-postfix converter.
// No dependencies; imported by the controller, the datapath and the top level.
package itp_pkg;

    // Operator codes held on the stack
    localparam logic [2:0] CODE_NONE  = 3'd0;
    localparam logic [2:0] CODE_OPEN  = 3'd1;
    localparam logic [2:0] CODE_PLUS  = 3'd2;
    localparam logic [2:0] CODE_MINUS = 3'd3;
    localparam logic [2:0] CODE_MUL   = 3'd4;
    localparam logic [2:0] CODE_DIV   = 3'd5;

    localparam logic [7:0] CHAR_OPEN  = 8'h28;
    localparam logic [7:0] CHAR_CLOSE = 8'h29;
    localparam logic [7:0] CHAR_MUL   = 8'h2A;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_DIV   = 8'h2F;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNMATCHED = 2'd2;

    localparam int DATA_W = 16;

    typedef enum logic [1:0] {
        K_PASS,
        K_OPEN,
        K_CLOSE,
        K_OP
    } kind_t;

    typedef struct packed {
        logic load;
        logic emit;
        logic emit_input;
        logic push;
        logic pop;
        logic finish;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  count_zero;
        logic  top_is_open;
        logic  pop_first;
        logic  end_flag;
        logic  pend_valid;
        logic  out_free;
    } sts_t;

    function automatic logic [2:0] char_to_code(input logic [7:0] c);
        logic [2:0] r;
        case (c)
            CHAR_OPEN:  r = CODE_OPEN;
            CHAR_PLUS:  r = CODE_PLUS;
            CHAR_MINUS: r = CODE_MINUS;
            CHAR_MUL:   r = CODE_MUL;
            CHAR_DIV:   r = CODE_DIV;
            default:    r = CODE_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] code_to_char(input logic [2:0] code);
        logic [7:0] r;
        case (code)
            CODE_OPEN:  r = CHAR_OPEN;
            CODE_PLUS:  r = CHAR_PLUS;
            CODE_MINUS: r = CHAR_MINUS;
            CODE_MUL:   r = CHAR_MUL;
            CODE_DIV:   r = CHAR_DIV;
            default:    r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] code_rank(input logic [2:0] code);
        logic [1:0] r;
        case (code)
            CODE_OPEN:  r = 2'd1;
            CODE_PLUS:  r = 2'd2;
            CODE_MINUS: r = 2'd2;
            CODE_MUL:   r = 2'd3;
            CODE_DIV:   r = 2'd3;
            default:    r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic kind_t char_kind(input logic [7:0] c);
        kind_t r;
        if (c == CHAR_CLOSE) begin
            r = K_CLOSE;
        end
        else if (c == CHAR_OPEN) begin
            r = K_OPEN;
        end
        else if (char_to_code(c) != CODE_NONE) begin
            r = K_OP;
        end
        else begin
            r = K_PASS;
        end
        return r;
    endfunction

endpackage

// ===== rtl/itp_datapath.sv =====
// Datapath of the infix-to-postfix converter: request registers, operator stack,
// one-deep pending result and output register. Depends on itp_pkg.
module itp_datapath
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        in_char,
    input  logic              in_end,
    input  cmd_t              cmd,
    output sts_t              sts,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data,   // [7:0] out_char, [9:8] status, rest zero
    output logic              out_user,   // has_char
    output logic              out_last    // last_of_run
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

    logic [7:0]    char_reg;
    logic          end_reg;
    kind_t         kind_reg;
    logic [2:0]    code_reg;
    logic [1:0]    status_reg;
    logic [1:0]    status_next;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] open_reg;
    logic [2:0]    top_reg;
    logic [2:0]    below_reg;
    logic [2:0]    op_stack [STACK_DEPTH];

    logic          push_ok;
    logic          wr_en;
    logic [CW-1:0] wr_full;
    logic [CW-1:0] rd_full;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    logic          pend_valid_reg;
    logic [7:0]    pend_char_reg;
    logic          out_valid_reg;
    logic [7:0]    out_char_reg;
    logic          out_has_reg;
    logic [1:0]    out_status_reg;
    logic          out_last_reg;

    logic [7:0]    emit_char;
    logic [2:0]    in_code;
    kind_t         in_kind;

    assign in_code = char_to_code(in_char);
    assign in_kind = char_kind(in_char);

    // Status of the request is fixed at load: an unmatched close is known from
    // the open count, an overflow only happens when no pop precedes the push.
    always_comb
    begin
        status_next = ST_OK;
        case (in_kind)
            K_CLOSE:
            begin
                if (open_reg == '0) begin
                    status_next = ST_UNMATCHED;
                end
            end
            K_OPEN:
            begin
                if (count_reg == FULL) begin
                    status_next = ST_OVERFLOW;
                end
            end
            K_OP:
            begin
                if ((count_reg == FULL) && (code_rank(in_code) > code_rank(top_reg))) begin
                    status_next = ST_OVERFLOW;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            char_reg   <= in_char;
            end_reg    <= in_end;
            kind_reg   <= in_kind;
            code_reg   <= in_code;
            status_reg <= status_next;
        end
    end

    // Stack: top in a register, the rest in memory; below_reg tracks the entry under top.
    assign push_ok = cmd.push && (count_reg != FULL);
    assign wr_en   = push_ok && (count_reg != '0);
    assign wr_full = count_reg - CW'(1);
    assign wr_addr = wr_full[AW-1:0];

    always_comb
    begin
        count_next = count_reg;
        if (push_ok) begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.pop) begin
            count_next = count_reg - CW'(1);
        end
    end

    assign rd_full = count_next - CW'(2);
    assign rd_addr = rd_full[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            op_stack[wr_addr] <= top_reg;
        end
        if (wr_en && (wr_addr == rd_addr)) begin
            below_reg <= top_reg;
        end
        else begin
            below_reg <= op_stack[rd_addr];
        end
        if (push_ok) begin
            top_reg <= code_reg;
        end
        else if (cmd.pop) begin
            top_reg <= below_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
            open_reg  <= '0;
        end
        else begin
            count_reg <= count_next;
            if (push_ok && (code_reg == CODE_OPEN)) begin
                open_reg <= open_reg + CW'(1);
            end
            else if (cmd.pop && (top_reg == CODE_OPEN)) begin
                open_reg <= open_reg - CW'(1);
            end
        end
    end

    // Result path: a new character waits in the pending slot until the next one
    // (or the end of the request) tells whether it is the last.
    assign emit_char = cmd.emit_input ? char_reg : code_to_char(top_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else begin
            if (cmd.emit) begin
                pend_valid_reg <= 1'b1;
                if (pend_valid_reg) begin
                    out_valid_reg <= 1'b1;
                end
                else if (out_ready) begin
                    out_valid_reg <= 1'b0;
                end
            end
            else if (cmd.finish) begin
                pend_valid_reg <= 1'b0;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit) begin
            pend_char_reg <= emit_char;
            if (pend_valid_reg) begin
                out_char_reg   <= pend_char_reg;
                out_has_reg    <= 1'b1;
                out_status_reg <= status_reg;
                out_last_reg   <= 1'b0;
            end
        end
        else if (cmd.finish) begin
            out_char_reg   <= pend_valid_reg ? pend_char_reg : 8'd0;
            out_has_reg    <= pend_valid_reg;
            out_status_reg <= status_reg;
            out_last_reg   <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {{(DATA_W - 10){1'b0}}, out_status_reg, out_char_reg};
    assign out_user  = out_has_reg;
    assign out_last  = out_last_reg;

    assign sts.kind        = kind_reg;
    assign sts.count_zero  = (count_reg == '0);
    assign sts.top_is_open = (top_reg == CODE_OPEN);
    assign sts.pop_first   = (code_rank(code_reg) <= code_rank(top_reg));
    assign sts.end_flag    = end_reg;
    assign sts.pend_valid  = pend_valid_reg;
    assign sts.out_free    = !out_valid_reg || out_ready;

endmodule

// ===== rtl/itp_ctrl.sv =====
// Controller of the infix-to-postfix converter: sequences load, pops, pushes and
// result emission for one request at a time. Depends on itp_pkg.
module itp_ctrl
    import itp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WORK,
        S_END
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   emit_ok;

    // A new character may enter the pending slot once the held one can move out.
    assign emit_ok  = !sts.pend_valid || sts.out_free;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_WORK;
                end
            end
            S_WORK:
            begin
                case (sts.kind)
                    K_PASS:
                    begin
                        if (emit_ok) begin
                            cmd.emit       = 1'b1;
                            cmd.emit_input = 1'b1;
                            state_next     = S_END;
                        end
                    end
                    K_OPEN:
                    begin
                        cmd.push   = 1'b1;
                        state_next = S_END;
                    end
                    K_CLOSE:
                    begin
                        if (sts.count_zero) begin
                            state_next = S_END;
                        end
                        else if (sts.top_is_open) begin
                            cmd.pop    = 1'b1;
                            state_next = S_END;
                        end
                        else if (emit_ok) begin
                            cmd.emit = 1'b1;
                            cmd.pop  = 1'b1;
                        end
                    end
                    K_OP:
                    begin
                        if (!sts.count_zero && sts.pop_first) begin
                            if (emit_ok) begin
                                cmd.emit = 1'b1;
                                cmd.pop  = 1'b1;
                            end
                        end
                        else begin
                            cmd.push   = 1'b1;
                            state_next = S_END;
                        end
                    end
                    default:
                    begin
                        state_next = S_END;
                    end
                endcase
            end
            S_END:
            begin
                if (sts.end_flag && !sts.count_zero) begin
                    if (emit_ok) begin
                        cmd.emit = 1'b1;
                        cmd.pop  = 1'b1;
                    end
                end
                else if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/infix_to_postfix_converter.sv =====
// Top level of the infix-to-postfix converter (shunting-yard scheme).
// Instantiates itp_ctrl and itp_datapath; depends on itp_pkg.
//
// Usage:
//   Input stream (s_*): one expression character per request in s_tdata[7:0],
//   s_tlast marks the final character of the expression; the operator stack
//   is flushed after it. A request is taken when s_tvalid and s_tready are high.
//   Output stream (m_*): one or more results per request. m_tdata[7:0] holds the
//   postfix character, m_tdata[9:8] the status (ok, overflow, unmatched close),
//   m_tuser says a character is present, m_tlast marks the last result of the
//   request. A request that yields no character gives one status-only result.
//   The operator stack does one push or one pop per cycle, fewer while the
//   receiver stalls; each operator that a request emits from the stack is popped
//   in turn, and the matched open parenthesis is popped without an emit.
//   The block works on one request at a time; s_tready is high only between
//   requests, while the final result of the previous one may still wait.
//   Reset clears the stack count and all valid flags; the stack is empty.
//   When the receiver stalls, the output register and a one-deep pending slot
//   hold results and the controller waits; nothing is dropped.
module infix_to_postfix_converter
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,    // [7:0] in_char
    input  logic              s_tlast,    // end_of_expr
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,    // [7:0] out_char, [9:8] status, [15:10] zero
    output logic              m_tuser,    // has_char
    output logic              m_tlast     // last_of_run
);

    cmd_t cmd;
    sts_t sts;

    // Sequence each request through load, pops, push and the final result.
    itp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold the stack and drive the result stream.
    itp_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_char   (s_tdata),
        .in_end    (s_tlast),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_user  (m_tuser),
        .out_last  (m_tlast)
    );

`ifndef SYNTHESIS
    // Never overwrite an output result that has not been taken.
    a_finish_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> sts.out_free)
        else $error("final result written over a held result");

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && sts.pend_valid) |-> sts.out_free)
        else $error("pending result moved over a held result");

    // A new request starts only with the pending slot drained.
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !sts.pend_valid)
        else $error("request accepted while a result is pending");

    // Only the last result of a request may be status-only.
    a_mid_has_char: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> m_tuser)
        else $error("status-only result before the end of a request");
`endif

endmodule
